>>> sv/mpbt_pkg.sv
// Shared types and helpers for the mouse position and button tracker.
// Used by every module of the block; no dependencies.
package mpbt_pkg;

  localparam int CntW   = 8;
  localparam int PosW   = 16;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_LEFT   = 2'd0;
  localparam logic [1:0] REG_WINDOW_RIGHT  = 2'd1;
  localparam logic [1:0] REG_WINDOW_TOP    = 2'd2;
  localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd3;

  // button event codes
  localparam logic [1:0] BTN_NONE     = 2'd0;
  localparam logic [1:0] BTN_PRESSED  = 2'd1;
  localparam logic [1:0] BTN_RELEASED = 2'd2;

  localparam logic [0:0] KIND_TICK  = 1'b0;
  localparam logic [0:0] KIND_START = 1'b1;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [CntW-1:0] delta_x;
    logic signed [CntW-1:0] delta_y;
    logic [1:0]             left_change;
    logic [1:0]             right_change;
    logic                   last;
  } mpbt_res_t;

  // up to two results from one tick, already packed towards e0
  typedef struct packed {
    logic [1:0] cnt;
    mpbt_res_t  e0;
    mpbt_res_t  e1;
  } mpbt_push_t;

  // pos + d, raised to lo first and then cut to hi (hi wins if inverted)
  function automatic logic signed [PosW-1:0] mpbt_clamp(
      input logic signed [PosW-1:0] pos,
      input logic signed [CntW-1:0] d,
      input logic signed [PosW-1:0] lo,
      input logic signed [PosW-1:0] hi);
    logic signed [PosW:0] sum;
    logic signed [PosW:0] v;
    logic signed [PosW:0] lo_w;
    logic signed [PosW:0] hi_w;
    sum  = {pos[PosW-1], pos} + {{(PosW-CntW+1){d[CntW-1]}}, d};
    lo_w = {lo[PosW-1], lo};
    hi_w = {hi[PosW-1], hi};
    v    = sum;
    if (v < lo_w) v = lo_w;
    if (v > hi_w) v = hi_w;
    return v[PosW-1:0];
  endfunction

endpackage

>>> sv/mpbt_front.sv
// Front end: accepts samples, holds window registers and tracking state,
// and turns each tick into zero, one or two result records. Uses mpbt_pkg.
module mpbt_front import mpbt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_idx,
  input  logic [PosW-1:0]        cfg_data,
  input  logic                   in_accept,
  input  logic                   in_kind,
  input  logic [CntW-1:0]        in_horiz_count,
  input  logic [CntW-1:0]        in_vert_count,
  input  logic                   in_left_level,
  input  logic                   in_right_level,
  output mpbt_push_t             push
);

  logic signed [PosW-1:0] win_left_r, win_right_r, win_top_r, win_bottom_r;
  logic [CntW-1:0]        hbase_r, hbase_nxt, vbase_r, vbase_nxt;
  logic signed [PosW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [CntW-1:0] hdx_r, hdx_nxt, hdy_r, hdy_nxt;
  logic [1:0]             btn_r, btn_nxt;

  logic [1:0]      btn, change;
  logic [CntW-1:0] dx, dy;
  logic            mx, my, moved;
  mpbt_res_t       mv_rec, bt_rec;

  assign btn    = {~in_right_level, ~in_left_level};
  assign dx     = in_horiz_count - hbase_r;
  assign dy     = in_vert_count - vbase_r;
  assign mx     = (dx != '0);
  assign my     = (dy != '0);
  assign moved  = mx | my;
  assign change = btn_r ^ btn;

  always_comb begin
    hbase_nxt = hbase_r;
    vbase_nxt = vbase_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    hdx_nxt   = hdx_r;
    hdy_nxt   = hdy_r;
    btn_nxt   = btn_r;
    if (in_kind == KIND_START) begin
      hbase_nxt = in_horiz_count;
      vbase_nxt = in_vert_count;
      btn_nxt   = btn;
      x_nxt     = win_left_r;
      y_nxt     = win_top_r;
    end else begin
      if (mx) begin
        x_nxt     = mpbt_clamp(x_r, dx, win_left_r, win_right_r);
        hdx_nxt   = dx;
        hbase_nxt = in_horiz_count;
      end
      if (my) begin
        y_nxt     = mpbt_clamp(y_r, dy, win_top_r, win_bottom_r);
        hdy_nxt   = dy;
        vbase_nxt = in_vert_count;
      end
      btn_nxt = btn;
    end
  end

  always_comb begin
    mv_rec              = '0;
    mv_rec.pos_x        = x_nxt;
    mv_rec.pos_y        = y_nxt;
    mv_rec.delta_x      = hdx_nxt;
    mv_rec.delta_y      = hdy_nxt;
    mv_rec.left_change  = BTN_NONE;
    mv_rec.right_change = BTN_NONE;
    mv_rec.last         = (change == 2'b00);

    bt_rec              = mv_rec;
    bt_rec.left_change  = !change[0] ? BTN_NONE : (btn[0] ? BTN_PRESSED : BTN_RELEASED);
    bt_rec.right_change = !change[1] ? BTN_NONE : (btn[1] ? BTN_PRESSED : BTN_RELEASED);
    bt_rec.last         = 1'b1;

    push    = '0;
    push.e0 = moved ? mv_rec : bt_rec;
    push.e1 = bt_rec;
    if (in_accept && in_kind == KIND_TICK) begin
      push.cnt = {1'b0, moved} + {1'b0, (change != 2'b00)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= 16'sd0;
      win_right_r  <= 16'sd319;
      win_top_r    <= 16'sd0;
      win_bottom_r <= 16'sd255;
      hbase_r      <= '0;
      vbase_r      <= '0;
      x_r          <= '0;
      y_r          <= '0;
      hdx_r        <= '0;
      hdy_r        <= '0;
      btn_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_WINDOW_LEFT:   win_left_r   <= cfg_data;
          REG_WINDOW_RIGHT:  win_right_r  <= cfg_data;
          REG_WINDOW_TOP:    win_top_r    <= cfg_data;
          REG_WINDOW_BOTTOM: win_bottom_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        hbase_r <= hbase_nxt;
        vbase_r <= vbase_nxt;
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        hdx_r   <= hdx_nxt;
        hdy_r   <= hdy_nxt;
        btn_r   <= btn_nxt;
      end
    end
  end

endmodule

>>> sv/mpbt_queue.sv
// Small result queue between front and back: takes up to two records a
// cycle, gives one. Uses mpbt_pkg.
module mpbt_queue import mpbt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mpbt_push_t push,
  input  logic       pop,
  output logic       q_nonempty,
  output mpbt_res_t  q_head,
  output logic       near_full
);

  mpbt_res_t        mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]   count_r;
  logic [QPtrW-1:0] wr_ptr1;

  assign wr_ptr1    = wr_ptr_r + 1'b1;
  assign q_nonempty = (count_r != '0);
  assign q_head     = mem[rd_ptr_r];
  // front may push two in any cycle it is not stalled
  assign near_full  = (count_r > (QPtrW+1)'(QDepth - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr_r] <= push.e0;
    if (push.cnt == 2'd2) mem[wr_ptr1]  <= push.e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPtrW'(push.cnt);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (QPtrW+1)'(push.cnt) - (QPtrW+1)'(pop);
    end
  end

endmodule

>>> sv/mpbt_back.sv
// Back end: output register that drains the result queue one transaction
// per cycle onto the result channel while out_stall is low. Uses mpbt_pkg.
module mpbt_back import mpbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nonempty,
  input  mpbt_res_t q_head,
  output logic      pop,
  input  logic      out_stall,
  output logic      out_valid,
  output mpbt_res_t out_rec
);

  logic      valid_r;
  mpbt_res_t rec_r;

  assign pop       = q_nonempty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_rec   = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rec_r <= q_head;
  end

endmodule

>>> sv/mouse_position_button_tracker.sv
// Top level of the mouse position and button tracker.
// Depends on mpbt_pkg, mpbt_front, mpbt_queue and mpbt_back.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | kind, horiz/vert count, button levels
//   out     | output    | out_valid/out_stall| position, deltas, button events, last
//   cfg     | input     | cfg_we             | cfg_idx, cfg_data (window bounds)
//
// A sample is taken every cycle while the four-entry result queue has room for
// two records; the front end updates all state in the cycle it accepts.
// The single output register delivers one result a cycle while out_stall is low,
// so a tick's two results leave one after another, each via the queue memory and
// then the output register. Synchronous reset clears state, loads default window.
// in_stall rises only from queue occupancy, independent of in_valid.
module mouse_position_button_tracker import mpbt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_idx,
  input  logic [PosW-1:0]        cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_kind,
  input  logic [CntW-1:0]        in_horiz_count,
  input  logic [CntW-1:0]        in_vert_count,
  input  logic                   in_left_level,
  input  logic                   in_right_level,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PosW-1:0] out_pos_x,
  output logic signed [PosW-1:0] out_pos_y,
  output logic signed [CntW-1:0] out_delta_x,
  output logic signed [CntW-1:0] out_delta_y,
  output logic [1:0]             out_left_change,
  output logic [1:0]             out_right_change,
  output logic                   out_last
);

  mpbt_push_t push;
  mpbt_res_t  q_head, out_rec;
  logic       q_nonempty, pop, near_full, in_accept;

  assign in_stall  = near_full;
  assign in_accept = in_valid && !near_full;

  mpbt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_accept      (in_accept),
    .in_kind        (in_kind),
    .in_horiz_count (in_horiz_count),
    .in_vert_count  (in_vert_count),
    .in_left_level  (in_left_level),
    .in_right_level (in_right_level),
    .push           (push)
  );

  mpbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .near_full  (near_full)
  );

  mpbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_rec    (out_rec)
  );

  assign out_pos_x        = out_rec.pos_x;
  assign out_pos_y        = out_rec.pos_y;
  assign out_delta_x      = out_rec.delta_x;
  assign out_delta_y      = out_rec.delta_y;
  assign out_left_change  = out_rec.left_change;
  assign out_right_change = out_rec.right_change;
  assign out_last         = out_rec.last;

endmodule

>>> dv/mouse_position_button_tracker_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for mouse_position_button_tracker: mouse samples and window settings
// in, position/button reports checked against an in-bench tracker model.
// Depends on mpbt_pkg and the mouse_position_button_tracker RTL.
module mouse_position_button_tracker_tb;
  import mpbt_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles with no transaction on either channel
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic       kind;
    logic [7:0] horiz;
    logic [7:0] vert;
    logic       left_lvl;
    logic       right_lvl;
  } mouse_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_idx = REG_WINDOW_LEFT;
  logic [PosW-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_kind = KIND_TICK;
  logic [CntW-1:0]  in_horiz_count = '0;
  logic [CntW-1:0]  in_vert_count = '0;
  logic             in_left_level = 1'b1;
  logic             in_right_level = 1'b1;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic signed [PosW-1:0] out_pos_x;
  logic signed [PosW-1:0] out_pos_y;
  logic signed [CntW-1:0] out_delta_x;
  logic signed [CntW-1:0] out_delta_y;
  logic [1:0]       out_left_change;
  logic [1:0]       out_right_change;
  logic             out_last;

  mouse_position_button_tracker uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_horiz_count  (in_horiz_count),
    .in_vert_count   (in_vert_count),
    .in_left_level   (in_left_level),
    .in_right_level  (in_right_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y),
    .out_left_change (out_left_change),
    .out_right_change(out_right_change),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // tracker model state and window copy
  logic [7:0]        h_base = '0, v_base = '0;
  logic signed [15:0] x_pos = '0, y_pos = '0;
  logic signed [7:0]  dx_held = '0, dy_held = '0;
  logic [1:0]         btn_down = '0;  // bit 0 left, bit 1 right
  logic signed [15:0] win_left = 16'sd0, win_right = 16'sd319;
  logic signed [15:0] win_top = 16'sd0, win_bottom = 16'sd255;

  mouse_sample_t samples_waiting[$];
  mpbt_res_t     expected_reports[$];
  mouse_sample_t cur_sample;

  int samples_queued = 0, samples_taken = 0, starts_taken = 0;
  int reports_seen = 0, button_reports = 0, double_ticks = 0;
  int windows_set = 0, mismatches = 0;
  int holds_asked = 0, holds_done = 0;

  // sum is formed wide, raised to lo, then cut to hi
  function automatic logic signed [15:0] move_axis(input logic signed [15:0] pos,
                                                   input logic signed [7:0] d,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
    int sum;
    sum = int'(pos) + int'(d);
    if (sum < int'(lo)) sum = int'(lo);
    if (sum > int'(hi)) sum = int'(hi);
    return 16'(sum);
  endfunction

  task automatic track_sample(input mouse_sample_t s);
    logic [1:0]        pressed;
    logic [1:0]        changed;
    logic signed [7:0] d;
    logic              moved;
    mpbt_res_t         r;
    pressed = {~s.right_lvl, ~s.left_lvl};
    if (s.kind == KIND_START) begin
      h_base = s.horiz;
      v_base = s.vert;
      btn_down = pressed;
      x_pos = win_left;
      y_pos = win_top;
      starts_taken++;
    end else begin
      moved = 1'b0;
      d = s.horiz - h_base;
      if (d != 0) begin
        x_pos = move_axis(x_pos, d, win_left, win_right);
        dx_held = d;
        h_base = s.horiz;
        moved = 1'b1;
      end
      d = s.vert - v_base;
      if (d != 0) begin
        y_pos = move_axis(y_pos, d, win_top, win_bottom);
        dy_held = d;
        v_base = s.vert;
        moved = 1'b1;
      end
      changed = btn_down ^ pressed;
      r.pos_x = x_pos;
      r.pos_y = y_pos;
      r.delta_x = dx_held;
      r.delta_y = dy_held;
      if (moved) begin
        r.left_change = BTN_NONE;
        r.right_change = BTN_NONE;
        r.last = (changed == 2'b00);
        expected_reports.push_back(r);
      end
      if (changed != 2'b00) begin
        btn_down = pressed;
        r.left_change = !changed[0] ? BTN_NONE : (pressed[0] ? BTN_PRESSED : BTN_RELEASED);
        r.right_change = !changed[1] ? BTN_NONE : (pressed[1] ? BTN_PRESSED : BTN_RELEASED);
        r.last = 1'b1;
        expected_reports.push_back(r);
        button_reports++;
        if (moved) double_ticks++;
      end
    end
  endtask

  // sender: bursts of random length, random gaps between them
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        track_sample(cur_sample);
        samples_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (samples_waiting.size() > 0) begin
          cur_sample = samples_waiting.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_sample.kind;
          in_horiz_count <= cur_sample.horiz;
          in_vert_count <= cur_sample.vert;
          in_left_level <= cur_sample.left_lvl;
          in_right_level <= cur_sample.right_lvl;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver: checks each report, stalls on a pattern of its own
  int rx_mode = 0, mode_left = 0, hold_left = 0, rx_cycle = 0;
  mpbt_res_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $display("%0t: report with nothing expected: pos (%0d,%0d)",
                   $time, out_pos_x, out_pos_y);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          report_field("pos_x", want.pos_x, out_pos_x);
          report_field("pos_y", want.pos_y, out_pos_y);
          report_field("delta_x", want.delta_x, out_delta_x);
          report_field("delta_y", want.delta_y, out_delta_y);
          report_field("left_change", want.left_change, out_left_change);
          report_field("right_change", want.right_change, out_right_change);
          report_field("last", want.last, out_last);
        end
      end
      if (hold_left == 0 && holds_done < holds_asked) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 4);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          3: out_stall <= ~out_stall;
          default: out_stall <= (rx_cycle % 4 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d reports outstanding",
             $time, QUIET_LIMIT, expected_reports.size());
    $display("mouse_position_button_tracker_tb: errors");
    $finish;
  end

  task automatic queue_sample(input logic kind, input logic [7:0] h, input logic [7:0] v,
                              input logic l, input logic r);
    mouse_sample_t s;
    s.kind = kind;
    s.horiz = h;
    s.vert = v;
    s.left_lvl = l;
    s.right_lvl = r;
    samples_waiting.push_back(s);
    samples_queued++;
  endtask

  // wait until everything sent has been taken and answered, then let the pipe empty
  task automatic settle;
    while (samples_taken != samples_queued || expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic signed [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
  endtask

  task automatic set_window(input logic signed [15:0] l, input logic signed [15:0] r,
                            input logic signed [15:0] t, input logic signed [15:0] b);
    write_reg(REG_WINDOW_LEFT, l);
    write_reg(REG_WINDOW_RIGHT, r);
    write_reg(REG_WINDOW_TOP, t);
    write_reg(REG_WINDOW_BOTTOM, b);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_left = l;
    win_right = r;
    win_top = t;
    win_bottom = b;
    windows_set++;
  endtask

  task automatic pick_span(output logic signed [15:0] lo, output logic signed [15:0] hi);
    logic signed [15:0] a, b;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(0, 5))
      0: begin lo = 16'sd0; hi = 16'sd300; end
      1: begin lo = -16'sd32768; hi = 16'sd32767; end
      2: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
      3: begin lo = (a < b) ? b : a; hi = (a < b) ? a : b; end  // inverted
      4: begin lo = a; hi = a; end
      default: begin
        lo = 16'($signed($urandom_range(0, 200)) - 100);
        hi = lo + 16'($urandom_range(0, 20));
      end
    endcase
  endtask

  function automatic logic [7:0] drift(input logic [7:0] c);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return c + 8'($urandom_range(0, 16)) - 8'd8;
      4, 5:       return c;
      8:          return c + (($urandom_range(0, 1) != 0) ? 8'd127 : 8'd128);
      default:    return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] gen_h, gen_v;
    logic gen_l, gen_r;
    logic signed [15:0] l, r, t, b;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: largest deltas both ways, clamping at each edge, wrap-around,
    // button press/release combinations, quiet tick, start keeping held deltas
    queue_sample(KIND_START, 8'h10, 8'hF0, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h10, 8'hF0, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h8F, 8'hF0, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h0F, 8'hF0, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h0F, 8'hEF, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h0F, 8'h6E, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h0F, 8'hED, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h0F, 8'h6C, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h10, 8'h6C, 1'b0, 1'b0);
    queue_sample(KIND_TICK, 8'h10, 8'h6C, 1'b1, 1'b0);
    queue_sample(KIND_TICK, 8'h10, 8'h6C, 1'b0, 1'b1);
    queue_sample(KIND_TICK, 8'hFF, 8'hFF, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h00, 8'h00, 1'b1, 1'b1);
    queue_sample(KIND_START, 8'hAA, 8'h55, 1'b0, 1'b0);
    queue_sample(KIND_TICK, 8'hAA, 8'h55, 1'b0, 1'b0);
    queue_sample(KIND_TICK, 8'hAA, 8'h55, 1'b1, 1'b0);
    settle();
    // window pinned at the positive x and negative y extremes
    set_window(16'sd32640, 16'sd32767, -16'sd32768, -16'sd32641);
    queue_sample(KIND_START, 8'h00, 8'h00, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h7F, 8'h80, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'hFE, 8'h00, 1'b1, 1'b1);
    settle();
    // inverted window: home lies outside, the upper bound wins
    set_window(16'sd100, -16'sd100, 16'sd50, -16'sd50);
    queue_sample(KIND_START, 8'h05, 8'h05, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h04, 8'h06, 1'b0, 1'b1);
    settle();
    set_window(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    queue_sample(KIND_START, 8'h80, 8'h7F, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'hFF, 8'hFE, 1'b1, 1'b1);
    queue_sample(KIND_TICK, 8'h7F, 8'h7E, 1'b0, 1'b0);
    settle();

    // random phases, each under a fresh window
    gen_h = 8'($urandom);
    gen_v = 8'($urandom);
    gen_l = 1'b1;
    gen_r = 1'b1;
    for (int phase = 0; phase < 12; phase++) begin
      pick_span(l, r);
      pick_span(t, b);
      set_window(l, r, t, b);
      // long receiver hold-off while the sender keeps offering
      if (phase == 2 || phase == 8) holds_asked++;
      queue_sample(KIND_START, gen_h, gen_v, gen_l, gen_r);
      for (int n = 0; n < 110; n++) begin
        gen_h = drift(gen_h);
        gen_v = drift(gen_v);
        if ($urandom_range(0, 6) == 0) gen_l = ~gen_l;
        if ($urandom_range(0, 6) == 0) gen_r = ~gen_r;
        queue_sample(($urandom_range(0, 99) < 3) ? KIND_START : KIND_TICK,
                     gen_h, gen_v, gen_l, gen_r);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d samples (%0d starts) under %0d window settings",
             samples_taken, starts_taken, windows_set + 1);
    $display("checked %0d reports: %0d button events, %0d ticks with two reports",
             reports_seen, button_reports, double_ticks);
    if (mismatches == 0) begin
      $display("mouse_position_button_tracker_tb: clean");
    end else begin
      $display("mouse_position_button_tracker_tb: errors");
    end
    $finish;
  end

endmodule
